// ----- rtl/fdt_pkg.sv -----
`default_nettype none
package fdt_pkg;

  localparam int MAX_PRECISION = 9;
  localparam int DEFAULT_PRECISION = 2;
  localparam int FIELD_W = 32;
  localparam int CHAR_W = 8;
  localparam int FD_W = 4;
  localparam int SCALE_W = 30;
  localparam int MANT_W = 24;
  localparam int PROD_W = MANT_W + SCALE_W;
  localparam int WORK_W = 64;
  localparam int CNT_W = 6;
  localparam int BCD_DIGITS = 19;
  localparam int BCD_W = 4 * BCD_DIGITS;
  localparam int IDX_W = 5;
  localparam int MUL_CNT_W = 5;
  localparam int CONV_CNT_W = 7;
  localparam int EXP_W = 9;
  localparam int RIGHT_LIMIT = 56;
  localparam int LEFT_LIMIT = 63;

  localparam logic [7:0] EXP_SPECIAL = 8'hFF;
  localparam logic [EXP_W-1:0] EXP_OFFSET = 9'd150;
  localparam logic [EXP_W-1:0] EXP_DENORM = 9'h16B;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_DOT = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;

  localparam logic REG_FRACTION_DIGITS = 1'b0;

  typedef enum logic [2:0] {
    CTL_IDLE, CTL_MUL, CTL_RND, CTL_ALIGN, CTL_ROUND, CTL_SHIFT, CTL_CONV, CTL_EMIT
  } ctl_state_t;

  typedef enum logic [2:0] {
    EM_IDLE, EM_FLAG, EM_SIGN, EM_DIGIT, EM_DOT
  } emit_state_t;

  typedef struct packed {
    logic            start;
    logic            flag;
    logic            neg;
    logic [FD_W-1:0] prec;
  } emit_req_t;

  function automatic logic [SCALE_W-1:0] pow10(input logic [FD_W-1:0] p);
    logic [SCALE_W-1:0] r;
    case (p)
      4'd1:    r = 30'd10;
      4'd2:    r = 30'd100;
      4'd3:    r = 30'd1000;
      4'd4:    r = 30'd10000;
      4'd5:    r = 30'd100000;
      4'd6:    r = 30'd1000000;
      4'd7:    r = 30'd10000000;
      4'd8:    r = 30'd100000000;
      4'd9:    r = 30'd1000000000;
      default: r = 30'd1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/fdt_in_if.sv -----
`default_nettype none
interface fdt_in_if;
  import fdt_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] float_bits;
  modport source(output valid, output float_bits, input ready);
  modport sink(input valid, input float_bits, output ready);
endinterface
`default_nettype wire

// ----- rtl/fdt_out_if.sv -----
`default_nettype none
interface fdt_out_if;
  import fdt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_char;
  logic              out_of_range;
  modport source(output valid, output out_char, output last_char, output out_of_range,
                 input ready);
  modport sink(input valid, input out_char, input last_char, input out_of_range,
               output ready);
endinterface
`default_nettype wire

// ----- rtl/fdt_mul.sv -----
`default_nettype none
module fdt_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fdt_pkg::MANT_W-1:0]    mcand,
  input  logic [fdt_pkg::SCALE_W-1:0]   mplier,
  output logic                          done,
  output logic [fdt_pkg::PROD_W-1:0]    prod
);
  import fdt_pkg::*;

  logic                  run;
  logic [MUL_CNT_W-1:0]  cnt;
  logic [MANT_W-1:0]     mc;
  logic [SCALE_W-1:0]    sc;
  logic [PROD_W-1:0]     addend;

  assign addend = sc[SCALE_W-1] ? PROD_W'(mc) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= MUL_CNT_W'(SCALE_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == MUL_CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc   <= mcand;
      sc   <= mplier;
      prod <= '0;
    end else if (run) begin
      prod <= {prod[PROD_W-2:0], 1'b0} + addend;
      sc   <= {sc[SCALE_W-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fdt_dabble.sv -----
`default_nettype none
module fdt_dabble (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fdt_pkg::WORK_W-1:0]  bin,
  output logic                        done,
  output logic [fdt_pkg::BCD_W-1:0]   bcd
);
  import fdt_pkg::*;

  logic                  run;
  logic [CONV_CNT_W-1:0] cnt;
  logic [WORK_W-1:0]     sh;
  logic [BCD_W-1:0]      adj;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CONV_CNT_W'(WORK_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CONV_CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= bin;
      bcd <= '0;
    end else if (run) begin
      bcd <= {adj[BCD_W-2:0], sh[WORK_W-1]};
      sh  <= {sh[WORK_W-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fdt_emit.sv -----
`default_nettype none
module fdt_emit (
  input  logic                       clk,
  input  logic                       rst,
  input  fdt_pkg::emit_req_t         req,
  input  logic [fdt_pkg::BCD_W-1:0]  bcd,
  output logic                       busy,
  fdt_out_if.source                  text
);
  import fdt_pkg::*;

  emit_state_t       ph, ph_next;
  logic [BCD_W-1:0]  dg, dg_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic              started, started_next;
  logic [FD_W-1:0]   prec, prec_next;
  logic              ov, ov_next;
  logic [CHAR_W-1:0] oc, oc_next;
  logic              ol, ol_next;
  logic              of, of_next;
  logic              slot_free;
  logic [3:0]        top_d;
  logic              at_point;

  assign slot_free = !ov || text.ready;
  assign top_d = dg[BCD_W-1 -: 4];
  assign at_point = idx == IDX_W'(prec);
  assign busy = ph != EM_IDLE;

  assign text.valid = ov;
  assign text.out_char = oc;
  assign text.last_char = ol;
  assign text.out_of_range = of;

  always_comb begin
    ph_next = ph;
    dg_next = dg;
    idx_next = idx;
    started_next = started;
    prec_next = prec;
    ov_next = ov && !text.ready;
    oc_next = oc;
    ol_next = ol;
    of_next = of;
    case (ph)
      EM_IDLE: begin
        if (req.start) begin
          dg_next = bcd;
          idx_next = IDX_W'(BCD_DIGITS - 1);
          started_next = 1'b0;
          prec_next = req.prec;
          if (req.flag) begin
            ph_next = EM_FLAG;
          end else if (req.neg) begin
            ph_next = EM_SIGN;
          end else begin
            ph_next = EM_DIGIT;
          end
        end
      end
      EM_FLAG: begin
        if (slot_free) begin
          ov_next = 1'b1;
          oc_next = CHAR_NONE;
          ol_next = 1'b1;
          of_next = 1'b1;
          ph_next = EM_IDLE;
        end
      end
      EM_SIGN: begin
        if (slot_free) begin
          ov_next = 1'b1;
          oc_next = CHAR_MINUS;
          ol_next = 1'b0;
          of_next = 1'b0;
          ph_next = EM_DIGIT;
        end
      end
      EM_DIGIT: begin
        if (!started && top_d == 4'd0 && idx > IDX_W'(prec)) begin
          dg_next = {dg[BCD_W-5:0], 4'd0};
          idx_next = idx - 1'b1;
        end else if (slot_free) begin
          ov_next = 1'b1;
          oc_next = CHAR_ZERO + CHAR_W'(top_d);
          ol_next = idx == '0;
          of_next = 1'b0;
          started_next = 1'b1;
          dg_next = {dg[BCD_W-5:0], 4'd0};
          idx_next = idx - 1'b1;
          if (at_point) begin
            ph_next = EM_DOT;
          end else if (idx == '0) begin
            ph_next = EM_IDLE;
          end
        end
      end
      EM_DOT: begin
        if (slot_free) begin
          ov_next = 1'b1;
          oc_next = CHAR_DOT;
          ol_next = 1'b0;
          of_next = 1'b0;
          ph_next = EM_DIGIT;
        end
      end
      default: begin
        ph_next = EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= EM_IDLE;
      ov <= 1'b0;
    end else begin
      ph <= ph_next;
      ov <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    dg <= dg_next;
    idx <= idx_next;
    started <= started_next;
    prec <= prec_next;
    oc <= oc_next;
    ol <= ol_next;
    of <= of_next;
  end

endmodule
`default_nettype wire

// ----- rtl/float_to_fixed_decimal_text_core.sv -----
// channel | dir | payload                              | transaction
// num     | in  | float_bits[31:0]                     | valid & ready
// text    | out | out_char[7:0], last_char, out_of_range | valid & ready
// cfg     | in  | APB, fraction_digits at byte 0        | psel & penable & pwrite
//
// One value at a time: a shift-add multiply, rounding, a bit-serial alignment shift
// (up to 63 bits left or 55 bits right), double dabble, then the characters: sign,
// BCD digits (19 positions, leading zeros above the point skipped) and point, each held
// while text stalls. NaN, infinity and out-of-range values emit one flagged character.
// Reset is synchronous on rst and clears control and fraction_digits.
// A stalled text channel holds the character register; num is taken again
// once the last character sits in that register.
`default_nettype none
module float_to_fixed_decimal_text_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  fdt_in_if.sink      num,
  fdt_out_if.source   text
);
  import fdt_pkg::*;

  ctl_state_t               state, state_next;
  logic [FD_W-1:0]          fd;
  logic [FD_W-1:0]          prec;
  logic [WORK_W-1:0]        w, w_next;
  logic signed [EXP_W-1:0]  ep, ep_next;
  logic [CNT_W-1:0]         cnt, cnt_next;
  logic                     left, left_next;
  logic                     ovf, ovf_next;
  logic                     neg, neg_next;

  logic [7:0]               exp_f;
  logic [MANT_W-1:0]        mant_in;
  logic signed [EXP_W-1:0]  e_in;
  logic                     neg_in;
  logic                     accept;
  logic [EXP_W-1:0]         kk;
  logic [WORK_W-1:0]        half;
  logic                     tie;
  logic                     rb_hi, rb_lo;

  logic                     mul_start, mul_done;
  logic [PROD_W-1:0]        prod;
  logic                     conv_start, conv_done;
  logic [BCD_W-1:0]         bcd;
  emit_req_t                emit_req;
  logic                     emit_busy;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRACTION_DIGITS) ? {28'd0, fd} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fd <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_FRACTION_DIGITS) begin
      fd <= pwdata[FD_W-1:0];
    end
  end

  always_comb begin
    if (fd == '0) begin
      prec = FD_W'(DEFAULT_PRECISION);
    end else if (fd > FD_W'(MAX_PRECISION)) begin
      prec = FD_W'(MAX_PRECISION);
    end else begin
      prec = fd;
    end
  end

  assign exp_f = num.float_bits[30:23];
  assign mant_in = {exp_f != 8'd0, num.float_bits[22:0]};
  assign e_in = (exp_f == 8'd0) ? $signed(EXP_DENORM) : $signed({1'b0, exp_f} - EXP_OFFSET);
  assign neg_in = num.float_bits[31] && (num.float_bits[30:0] != 31'd0);
  assign num.ready = state == CTL_IDLE;
  assign accept = num.valid && num.ready;

  assign kk = EXP_W'(-ep);
  always_comb begin
    half = '0;
    for (int i = 0; i < RIGHT_LIMIT; i++) begin
      half[i] = kk == EXP_W'(i + 1);
    end
  end
  assign tie = (ep == '0) && !w[53] && w[52] && w[0];
  assign rb_hi = w[1] && (w[0] || w[2]);
  assign rb_lo = w[0] && w[1];

  always_comb begin
    state_next = state;
    w_next = w;
    ep_next = ep;
    cnt_next = cnt;
    left_next = left;
    ovf_next = ovf;
    neg_next = neg;
    mul_start = 1'b0;
    conv_start = 1'b0;
    emit_req = '{start: 1'b0, flag: 1'b0, neg: neg, prec: prec};
    case (state)
      CTL_IDLE: begin
        if (accept) begin
          neg_next = neg_in;
          ep_next = e_in;
          if (exp_f == EXP_SPECIAL) begin
            emit_req.start = 1'b1;
            emit_req.flag = 1'b1;
            state_next = CTL_EMIT;
          end else begin
            mul_start = 1'b1;
            state_next = CTL_MUL;
          end
        end
      end
      CTL_MUL: begin
        if (mul_done) begin
          w_next = WORK_W'(prod);
          state_next = CTL_RND;
        end
      end
      CTL_RND: begin
        if (w[53]) begin
          w_next = {1'b0, w[WORK_W-1:1]} + WORK_W'(rb_lo);
          ep_next = ep + EXP_W'(1);
        end
        state_next = CTL_ALIGN;
      end
      CTL_ALIGN: begin
        ovf_next = 1'b0;
        cnt_next = '0;
        left_next = 1'b1;
        state_next = CTL_SHIFT;
        if (!ep[EXP_W-1]) begin
          if (ep > EXP_W'(LEFT_LIMIT)) begin
            ovf_next = 1'b1;
          end else begin
            w_next = w + WORK_W'(tie);
            cnt_next = ep[CNT_W-1:0];
          end
        end else if (kk >= EXP_W'(RIGHT_LIMIT)) begin
          w_next = '0;
        end else begin
          w_next = w + half;
          cnt_next = kk[CNT_W-1:0];
          left_next = 1'b0;
          state_next = CTL_ROUND;
        end
      end
      CTL_ROUND: begin
        if (w[54]) begin
          w_next = {w[WORK_W-1:2], 2'b00} + (rb_hi ? WORK_W'(4) : '0);
        end else if (w[53]) begin
          w_next = {w[WORK_W-1:1], 1'b0} + (rb_lo ? WORK_W'(2) : '0);
        end
        state_next = CTL_SHIFT;
      end
      CTL_SHIFT: begin
        if (cnt == '0) begin
          if (ovf || w[WORK_W-1]) begin
            emit_req.start = 1'b1;
            emit_req.flag = 1'b1;
            state_next = CTL_EMIT;
          end else begin
            conv_start = 1'b1;
            state_next = CTL_CONV;
          end
        end else begin
          cnt_next = cnt - 1'b1;
          if (left) begin
            ovf_next = ovf || w[WORK_W-1];
            w_next = {w[WORK_W-2:0], 1'b0};
          end else begin
            w_next = {1'b0, w[WORK_W-1:1]};
          end
        end
      end
      CTL_CONV: begin
        if (conv_done) begin
          emit_req.start = 1'b1;
          state_next = CTL_EMIT;
        end
      end
      CTL_EMIT: begin
        if (!emit_busy) begin
          state_next = CTL_IDLE;
        end
      end
      default: begin
        state_next = CTL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    w <= w_next;
    ep <= ep_next;
    cnt <= cnt_next;
    left <= left_next;
    ovf <= ovf_next;
    neg <= neg_next;
  end

  fdt_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mant_in),
    .mplier (pow10(prec)),
    .done   (mul_done),
    .prod   (prod)
  );

  fdt_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .bin   (w),
    .done  (conv_done),
    .bcd   (bcd)
  );

  fdt_emit u_emit (
    .clk  (clk),
    .rst  (rst),
    .req  (emit_req),
    .bcd  (bcd),
    .busy (emit_busy),
    .text (text)
  );

endmodule
`default_nettype wire
